/* hw/rtl/bmpas_pkg.sv */
// Shared constants and types of the aspect-fit scaler address generator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bmpas_pkg;

  // Largest fitted draw size per axis
  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int FIT_W   = $clog2(MAX_DIM + 1);

  // Register field widths
  localparam int POFF_W = 24;
  localparam int SRCW_W = 13;
  localparam int SRCH_W = 14;
  localparam int BOX_W  = 13;
  localparam int POS_W  = 12;

  // Result field widths
  localparam int SCR_W  = 13;
  localparam int BOFF_W = 26;

  // Divider operand widths: fit ratio numerator or pixel index times source size
  localparam int DVD_W = (CNT_W + SRCH_W > SRCH_W + BOX_W) ? CNT_W + SRCH_W
                                                          : SRCH_W + BOX_W;
  localparam int DVS_W = (FIT_W > SRCH_W) ? FIT_W : SRCH_W;

  // Row pitch: 3 bytes per pixel, padded to 4-byte multiple
  localparam int RB_W = SRCW_W + 2;
  localparam logic [RB_W-1:0] ROW_ALIGN_MASK = ~RB_W'(3);

  // APB port
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset values
  localparam logic [POFF_W-1:0] RST_DATA_OFFSET = POFF_W'(54);
  localparam logic [SRCW_W-1:0] RST_SRC_WIDTH   = SRCW_W'(1);
  localparam logic [SRCH_W-1:0] RST_SRC_HEIGHT  = SRCH_W'(1);
  localparam logic [BOX_W-1:0]  RST_BOX_SIZE    = BOX_W'(1);
  localparam logic [POS_W-1:0]  RST_BOX_POS     = POS_W'(0);

  typedef enum logic [2:0] {
    REG_DATA_OFFSET = 3'd0,
    REG_SRC_WIDTH   = 3'd1,
    REG_SRC_HEIGHT  = 3'd2,
    REG_BOX_WIDTH   = 3'd3,
    REG_BOX_HEIGHT  = 3'd4,
    REG_BOX_LEFT    = 3'd5,
    REG_BOX_TOP     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        [POFF_W-1:0] data_offset;
    logic        [SRCW_W-1:0] src_width;
    logic signed [SRCH_W-1:0] src_height;
    logic        [BOX_W-1:0]  box_width;
    logic        [BOX_W-1:0]  box_height;
    logic        [POS_W-1:0]  box_left;
    logic        [POS_W-1:0]  box_top;
  } cfg_t;

  // Request handed from front to back
  typedef struct packed {
    logic valid;
    logic restart;
  } req_t;

endpackage

`default_nettype wire

/* hw/rtl/bmp_aspect_fit_scaler_addresses_core.sv */
// Top level of the aspect-fit nearest-neighbor scaler address generator.
// Depends on bmpas_pkg, bmpas_cfg, bmpas_front, bmpas_back (and bmpas_div).
//
//   channel   direction  handshake                 payload
//   config    in         psel/penable/pwrite/pready paddr, pwdata -> prdata
//   request   in         push / full               restart_i
//   result    out        empty / pop               screen_x_o, screen_y_o,
//                                                  src_byte_offset_o, last_pixel_o
//
// One request yields one result. A plain request passes the back-end steps
// dispatch, multiply, divider start, 27 divide steps plus a done step, offset
// and output. A restart first works out the fit ratio on the column divider
// (skipped when source width and height are both zero).
// Reset loads the register defaults, a 1 by 1 fit and zero counters; no
// clearing pass. The two-entry request queue keeps accepting while the back
// end works; the back end stalls only in its output step while a result waits.
`default_nettype none

module bmp_aspect_fit_scaler_addresses_core import bmpas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // requests
  input  logic               push,
  output logic               full,
  input  logic               restart_i,
  // results
  output logic               empty,
  input  logic               pop,
  output logic [SCR_W-1:0]   screen_x_o,
  output logic [SCR_W-1:0]   screen_y_o,
  output logic [BOFF_W-1:0]  src_byte_offset_o,
  output logic               last_pixel_o
);

  cfg_t cfg;
  req_t req;
  logic req_pop;

  // geometry registers
  bmpas_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // hold incoming requests, tagged as restart or next pixel
  bmpas_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .restart_i (restart_i),
    .req_o     (req),
    .req_pop_i (req_pop)
  );

  // latch the fit, advance the raster scan and form the addresses
  bmpas_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .req_i             (req),
    .req_pop_o         (req_pop),
    .pop_i             (pop),
    .empty_o           (empty),
    .screen_x_o        (screen_x_o),
    .screen_y_o        (screen_y_o),
    .src_byte_offset_o (src_byte_offset_o),
    .last_pixel_o      (last_pixel_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/bmpas_cfg.sv */
// APB register file holding the image and box geometry.
// Depends on bmpas_pkg.
`default_nettype none

module bmpas_cfg import bmpas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_offset <= RST_DATA_OFFSET;
      cfg_q.src_width   <= RST_SRC_WIDTH;
      cfg_q.src_height  <= RST_SRC_HEIGHT;
      cfg_q.box_width   <= RST_BOX_SIZE;
      cfg_q.box_height  <= RST_BOX_SIZE;
      cfg_q.box_left    <= RST_BOX_POS;
      cfg_q.box_top     <= RST_BOX_POS;
    end else if (wr_en) begin
      unique case (idx)
        REG_DATA_OFFSET: cfg_q.data_offset <= pwdata[POFF_W-1:0];
        REG_SRC_WIDTH:   cfg_q.src_width   <= pwdata[SRCW_W-1:0];
        REG_SRC_HEIGHT:  cfg_q.src_height  <= pwdata[SRCH_W-1:0];
        REG_BOX_WIDTH:   cfg_q.box_width   <= pwdata[BOX_W-1:0];
        REG_BOX_HEIGHT:  cfg_q.box_height  <= pwdata[BOX_W-1:0];
        REG_BOX_LEFT:    cfg_q.box_left    <= pwdata[POS_W-1:0];
        REG_BOX_TOP:     cfg_q.box_top     <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DATA_OFFSET: prdata = DATA_W'(cfg_q.data_offset);
      REG_SRC_WIDTH:   prdata = DATA_W'(cfg_q.src_width);
      REG_SRC_HEIGHT:  prdata = DATA_W'($unsigned(cfg_q.src_height));
      REG_BOX_WIDTH:   prdata = DATA_W'(cfg_q.box_width);
      REG_BOX_HEIGHT:  prdata = DATA_W'(cfg_q.box_height);
      REG_BOX_LEFT:    prdata = DATA_W'(cfg_q.box_left);
      REG_BOX_TOP:     prdata = DATA_W'(cfg_q.box_top);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bmpas_front.sv */
// Front end: request queue that accepts and classifies incoming requests.
// Depends on bmpas_pkg.
`default_nettype none

module bmpas_front import bmpas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  logic restart_i,
  output req_t req_o,
  input  logic req_pop_i
);

  logic              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push_acc, pop_acc;

  assign full_o      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push_acc    = push_i && !full_o;
  assign pop_acc     = req_pop_i && (cnt_q != '0);
  assign req_o.valid   = (cnt_q != '0);
  assign req_o.restart = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      mem_q[wr_ptr_q] <= restart_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_acc) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_acc)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_acc && !pop_acc) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_acc && !push_acc) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bmpas_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on bmpas_pkg for operand widths.
`default_nettype none

module bmpas_div import bmpas_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int DCNT_W = $clog2(DVD_W + 1);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q, dvs_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W:0]    rem_sh, rem_sub;
  logic              take;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    take    = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // pulse done after the last quotient bit
      done_q <= !start_i && busy_q && (cnt_q == DCNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DVD_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        // shift in next dividend bit, subtract where it fits
        rem_q <= take ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], take};
        cnt_q <= cnt_q - DCNT_W'(1);
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/bmpas_back.sv */
// Back end: fit latch, pixel counters, address arithmetic and result register.
// Depends on bmpas_pkg and bmpas_div.
`default_nettype none

module bmpas_back import bmpas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  req_t              req_i,
  output logic              req_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [SCR_W-1:0]  screen_x_o,
  output logic [SCR_W-1:0]  screen_y_o,
  output logic [BOFF_W-1:0] src_byte_offset_o,
  output logic              last_pixel_o
);

  localparam int WBH_W = SRCW_W + BOX_W;
  localparam int HBW_W = SRCH_W + BOX_W;
  localparam int NX_W  = CNT_W + SRCW_W;
  localparam int NY_W  = CNT_W + SRCH_W;
  localparam int OFF_W = SRCH_W + RB_W;
  localparam int CW    = ((FIT_W > BOX_W) ? FIT_W : BOX_W) + 1;
  localparam int SX3_W = SRCW_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_FIT_MUL, S_FIT_DIV, S_FIT_WAIT,
    S_PIX_MUL, S_PIX_DIV, S_PIX_WAIT, S_PIX_OFF, S_OUT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   col_q, row_q;
  logic [FIT_W-1:0]   fit_w_q, fit_h_q;
  logic               use_w_q;
  logic [WBH_W-1:0]   prod_wbh_q;
  logic [HBW_W-1:0]   prod_hbw_q;
  logic [NX_W-1:0]    num_x_q;
  logic [NY_W-1:0]    num_y_q;
  logic [BOFF_W-1:0]  off_q;
  logic               out_valid_q;
  logic [SCR_W-1:0]   scr_x_q, scr_y_q;
  logic [BOFF_W-1:0]  boff_q;
  logic               last_q;

  logic [SRCW_W-1:0]  w;
  logic [SRCH_W-1:0]  h_abs;
  logic               flipped, use_w, h_nz;
  logic               dx_start, dy_start, dx_done, dy_done;
  logic [DVD_W-1:0]   dx_dvd, dx_quo, dy_quo;
  logic [DVS_W-1:0]   dx_dvs;
  logic [RB_W-1:0]    row_bytes;
  logic [SRCW_W-1:0]  sx;
  logic [SRCH_W-1:0]  sy;
  logic [OFF_W-1:0]   off_full;
  logic [SX3_W-1:0]   sx3;
  logic [CW-1:0]      bw_e, bh_e, fw_e, fh_e, ctr_x, ctr_y;
  logic [FIT_W-1:0]   col_inc, row_inc, dy;
  logic               col_wrap, row_wrap, out_load;
  logic [SCR_W-1:0]   scr_x_d, scr_y_d;
  logic [BOFF_W-1:0]  boff_d;

  function automatic logic [FIT_W-1:0] clamp_dim(input logic [DVD_W-1:0] v);
    logic [FIT_W-1:0] r;
    if (v == '0) begin
      r = FIT_W'(1);
    end else if (v > DVD_W'(MAX_DIM)) begin
      r = FIT_W'(MAX_DIM);
    end else begin
      r = FIT_W'(v);
    end
    return r;
  endfunction

  always_comb begin
    w       = cfg_i.src_width;
    flipped = !cfg_i.src_height[SRCH_W-1];
    h_abs   = cfg_i.src_height[SRCH_W-1] ? SRCH_W'(-cfg_i.src_height)
                                         : SRCH_W'(cfg_i.src_height);
    h_nz    = (h_abs != '0);
    use_w   = (w != '0) && ({1'b0, prod_wbh_q} >= prod_hbw_q);

    if (state_q == S_FIT_DIV) begin
      dx_dvd = use_w ? DVD_W'(prod_hbw_q) : DVD_W'(prod_wbh_q);
      dx_dvs = use_w ? DVS_W'(w) : DVS_W'(h_abs);
    end else begin
      dx_dvd = DVD_W'(num_x_q);
      dx_dvs = DVS_W'(fit_w_q);
    end
    dx_start = ((state_q == S_FIT_DIV) && (use_w || h_nz)) || (state_q == S_PIX_DIV);
    dy_start = (state_q == S_PIX_DIV);

    row_bytes = (RB_W'(w) + RB_W'({w, 1'b0}) + RB_W'(3)) & ROW_ALIGN_MASK;
    sx        = dx_quo[SRCW_W-1:0];
    sy        = dy_quo[SRCH_W-1:0];
    off_full  = OFF_W'(sy) * OFF_W'(row_bytes);
    sx3       = SX3_W'(sx) + SX3_W'({sx, 1'b0});

    // centering, clipped to zero where the draw area outgrows the box
    bw_e  = CW'(cfg_i.box_width);
    bh_e  = CW'(cfg_i.box_height);
    fw_e  = CW'(fit_w_q);
    fh_e  = CW'(fit_h_q);
    ctr_x = (bw_e > fw_e) ? ((bw_e - fw_e) >> 1) : '0;
    ctr_y = (bh_e > fh_e) ? ((bh_e - fh_e) >> 1) : '0;

    col_inc  = FIT_W'(col_q) + FIT_W'(1);
    row_inc  = FIT_W'(row_q) + FIT_W'(1);
    col_wrap = (col_inc >= fit_w_q);
    row_wrap = (row_inc >= fit_h_q);
    dy       = flipped ? (fit_h_q - FIT_W'(1) - FIT_W'(row_q)) : FIT_W'(row_q);

    scr_x_d = SCR_W'(cfg_i.box_left) + SCR_W'(ctr_x) + SCR_W'(col_q);
    scr_y_d = SCR_W'(cfg_i.box_top) + SCR_W'(ctr_y) + SCR_W'(dy);
    boff_d  = BOFF_W'(cfg_i.data_offset) + off_q + BOFF_W'(sx3);

    out_load  = (state_q == S_OUT) && (!out_valid_q || pop_i);
    req_pop_o = (state_q == S_IDLE) && req_i.valid;
  end

  bmpas_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dx_start),
    .dividend_i (dx_dvd),
    .divisor_i  (dx_dvs),
    .done_o     (dx_done),
    .quotient_o (dx_quo)
  );

  bmpas_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dy_start),
    .dividend_i (DVD_W'(num_y_q)),
    .divisor_i  (DVS_W'(fit_h_q)),
    .done_o     (dy_done),
    .quotient_o (dy_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      fit_w_q     <= FIT_W'(1);
      fit_h_q     <= FIT_W'(1);
      use_w_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (pop_i && out_valid_q && !out_load) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) state_q <= req_i.restart ? S_FIT_MUL : S_PIX_MUL;
        end
        S_FIT_MUL: begin
          prod_wbh_q <= WBH_W'(w) * WBH_W'(cfg_i.box_height);
          prod_hbw_q <= HBW_W'(h_abs) * HBW_W'(cfg_i.box_width);
          col_q      <= '0;
          row_q      <= '0;
          state_q    <= S_FIT_DIV;
        end
        S_FIT_DIV: begin
          use_w_q <= use_w;
          if (use_w || h_nz) begin
            state_q <= S_FIT_WAIT;
          end else begin
            fit_w_q <= FIT_W'(1);
            fit_h_q <= FIT_W'(1);
            state_q <= S_PIX_MUL;
          end
        end
        S_FIT_WAIT: begin
          if (dx_done) begin
            if (use_w_q) begin
              fit_w_q <= clamp_dim(DVD_W'(cfg_i.box_width));
              fit_h_q <= clamp_dim(dx_quo);
            end else begin
              fit_h_q <= clamp_dim(DVD_W'(cfg_i.box_height));
              fit_w_q <= clamp_dim(dx_quo);
            end
            state_q <= S_PIX_MUL;
          end
        end
        S_PIX_MUL: begin
          num_x_q <= NX_W'(col_q) * NX_W'(w);
          num_y_q <= NY_W'(row_q) * NY_W'(h_abs);
          state_q <= S_PIX_DIV;
        end
        S_PIX_DIV: begin
          state_q <= S_PIX_WAIT;
        end
        S_PIX_WAIT: begin
          if (dx_done && dy_done) state_q <= S_PIX_OFF;
        end
        S_PIX_OFF: begin
          off_q   <= off_full[BOFF_W-1:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            scr_x_q     <= scr_x_d;
            scr_y_q     <= scr_y_d;
            boff_q      <= boff_d;
            last_q      <= col_wrap && row_wrap;
            out_valid_q <= 1'b1;
            if (col_wrap) begin
              col_q <= '0;
              row_q <= row_wrap ? '0 : CNT_W'(row_inc);
            end else begin
              col_q <= CNT_W'(col_inc);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign empty_o           = !out_valid_q;
  assign screen_x_o        = scr_x_q;
  assign screen_y_o        = scr_y_q;
  assign src_byte_offset_o = boff_q;
  assign last_pixel_o      = last_q;

`ifndef ASSERT_OFF
  a_col_in_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FIT_W'(col_q) < fit_w_q)
    else $error("column counter beyond fitted width");

  a_row_in_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FIT_W'(row_q) < fit_h_q)
    else $error("row counter beyond fitted height");

  a_fit_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fit_w_q != '0) && (fit_w_q <= FIT_W'(MAX_DIM)) &&
    (fit_h_q != '0) && (fit_h_q <= FIT_W'(MAX_DIM)))
    else $error("fitted size out of range");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for the aspect-fit scaler address generator: directed scans of the corner
// cases, then random configurations and pixel scans checked against an in-bench model.
// Depends on bmpas_pkg and bmp_aspect_fit_scaler_addresses_core.
module tb_top;
  import bmpas_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  // Requests sent with no idling at the end of the run
  localparam int QUIET_TAIL   = 250;
  // Cycles to wait after the last result
  localparam int DRAIN_CYCLES = 80;
  // Watchdog limit: several times the slowest correct run
  localparam int TIME_LIMIT   = 4_000_000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [SCR_W-1:0]  screen_x;
    logic [SCR_W-1:0]  screen_y;
    logic [BOFF_W-1:0] byte_offset;
    logic              last_pixel;
  } pixel_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               push;
  logic               full;
  logic               restart_i;
  logic               empty;
  logic               pop;
  logic [SCR_W-1:0]   screen_x_o;
  logic [SCR_W-1:0]   screen_y_o;
  logic [BOFF_W-1:0]  src_byte_offset_o;
  logic               last_pixel_o;

  // Model state: register copy, latched fit and raster position
  cfg_t             shadow_cfg;
  logic [FIT_W-1:0] draw_w;
  logic [FIT_W-1:0] draw_h;
  logic [CNT_W-1:0] col_pos;
  logic [CNT_W-1:0] row_pos;

  pixel_t pending_pixels[$];

  bit allow_idle;
  int items_sent;
  int restarts_sent;
  int pixels_checked;
  int last_pixels_seen;
  int config_phases;
  int mismatches;

  bmp_aspect_fit_scaler_addresses_core i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .push              (push),
    .full              (full),
    .restart_i         (restart_i),
    .empty             (empty),
    .pop               (pop),
    .screen_x_o        (screen_x_o),
    .screen_y_o        (screen_y_o),
    .src_byte_offset_o (src_byte_offset_o),
    .last_pixel_o      (last_pixel_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pixel address model
  // ---------------------------------------------------------------------------

  // Row count of the source: magnitude of the signed height
  function automatic longint unsigned src_rows();
    longint signed_rows;
    signed_rows = $signed(shadow_cfg.src_height);
    return (signed_rows < 0) ? -signed_rows : signed_rows;
  endfunction

  function automatic logic [FIT_W-1:0] clamp_dim(input longint unsigned v);
    if (v < 1) return FIT_W'(1);
    if (v > MAX_DIM) return FIT_W'(MAX_DIM);
    return FIT_W'(v);
  endfunction

  // Scale by the larger source/box ratio so the image fits the box
  task automatic fit_draw_area();
    longint unsigned w, h, bw, bh, dw, dh;
    w  = shadow_cfg.src_width;
    h  = src_rows();
    bw = shadow_cfg.box_width;
    bh = shadow_cfg.box_height;
    if (w > 0 && w * bh >= h * bw) begin
      dw = bw;
      dh = h * bw / w;
    end else if (h > 0) begin
      dh = bh;
      dw = w * bh / h;
    end else begin
      dw = 1;
      dh = 1;
    end
    draw_w = clamp_dim(dw);
    draw_h = clamp_dim(dh);
  endtask

  // Work out the pixel that one accepted request yields and queue it
  task automatic predict_pixel(input logic restart);
    longint unsigned w, h, bw, bh, fw, fh, col, row;
    longint unsigned xoff, yoff, dy, rowbytes, sx, sy;
    int unsigned     next_col, next_row;
    pixel_t          px;
    w = shadow_cfg.src_width;
    h = src_rows();
    if (restart) begin
      fit_draw_area();
      col_pos = '0;
      row_pos = '0;
    end
    bw  = shadow_cfg.box_width;
    bh  = shadow_cfg.box_height;
    fw  = draw_w;
    fh  = draw_h;
    col = col_pos;
    row = row_pos;
    // A draw area wider or taller than the box gets no centering offset
    xoff = shadow_cfg.box_left + ((bw > fw) ? (bw - fw) / 2 : 0);
    yoff = shadow_cfg.box_top + ((bh > fh) ? (bh - fh) / 2 : 0);
    // Bottom-up sources are mirrored vertically
    dy = shadow_cfg.src_height[SRCH_W-1] ? row : fh - 1 - row;
    rowbytes = (w * 3 + 3) & ~64'd3;
    sx = col * w / fw;
    sy = row * h / fh;
    px.screen_x    = SCR_W'(xoff + col);
    px.screen_y    = SCR_W'(yoff + dy);
    px.byte_offset = BOFF_W'(shadow_cfg.data_offset + sy * rowbytes + sx * 3);
    px.last_pixel  = (col + 1 >= fw) && (row + 1 >= fh);
    pending_pixels.push_back(px);
    // Advance in raster order and wrap to the first pixel after the last
    next_col = col_pos + 1;
    if (next_col >= fw) begin
      col_pos  = '0;
      next_row = row_pos + 1;
      row_pos  = (next_row >= fh) ? '0 : CNT_W'(next_row);
    end else begin
      col_pos = CNT_W'(next_col);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DATA_OFFSET: shadow_cfg.data_offset = value[POFF_W-1:0];
      REG_SRC_WIDTH:   shadow_cfg.src_width   = value[SRCW_W-1:0];
      REG_SRC_HEIGHT:  shadow_cfg.src_height  = value[SRCH_W-1:0];
      REG_BOX_WIDTH:   shadow_cfg.box_width   = value[BOX_W-1:0];
      REG_BOX_HEIGHT:  shadow_cfg.box_height  = value[BOX_W-1:0];
      REG_BOX_LEFT:    shadow_cfg.box_left    = value[POS_W-1:0];
      REG_BOX_TOP:     shadow_cfg.box_top     = value[POS_W-1:0];
      default: ;
    endcase
  endtask

  // Send one request; push stays high afterwards so back-to-back requests
  // never see push dropped and raised in the same step
  task automatic send_pixel_request(input logic restart);
    int gap;
    if (allow_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      push      <= 1'b0;
      restart_i <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (full);
    predict_pixel(restart);
    items_sent++;
    if (restart) restarts_sent++;
  endtask

  // Drop push and hold until every queued pixel has been checked
  task automatic wait_for_results();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Keep the low bits of a register value, fill the rest with noise
  function automatic logic [DATA_W-1:0] dressed(input logic [DATA_W-1:0] v, input int w);
    logic [DATA_W-1:0] low_mask;
    low_mask = (DATA_W'(1) << w) - 1;
    return ($urandom & ~low_mask) | (v & low_mask);
  endfunction

  task automatic apply_config(input logic [DATA_W-1:0] poff, input logic [DATA_W-1:0] sw,
                              input logic [DATA_W-1:0] sh, input logic [DATA_W-1:0] bw,
                              input logic [DATA_W-1:0] bh, input logic [DATA_W-1:0] bl,
                              input logic [DATA_W-1:0] bt);
    wait_for_results();
    config_phases++;
    write_reg(REG_DATA_OFFSET, poff);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_BOX_WIDTH, bw);
    write_reg(REG_BOX_HEIGHT, bh);
    write_reg(REG_BOX_LEFT, bl);
    write_reg(REG_BOX_TOP, bt);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: pop with random stall bursts, compare with oldest pixel
  // ---------------------------------------------------------------------------

  task automatic check_pixel();
    pixel_t got, want;
    got.screen_x    = screen_x_o;
    got.screen_y    = screen_y_o;
    got.byte_offset = src_byte_offset_o;
    got.last_pixel  = last_pixel_o;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: unexpected result x=%0d y=%0d offset=%0d last=%0b",
                 got.screen_x, got.screen_y, got.byte_offset, got.last_pixel);
      return;
    end
    want = pending_pixels.pop_front();
    pixels_checked++;
    if (got.last_pixel) last_pixels_seen++;
    if (got != want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("ERROR: pixel %0d mismatch", pixels_checked);
        $display("  screen_x    exp %0d got %0d", want.screen_x, got.screen_x);
        $display("  screen_y    exp %0d got %0d", want.screen_y, got.screen_y);
        $display("  byte_offset exp %0d got %0d", want.byte_offset, got.byte_offset);
        $display("  last_pixel  exp %0b got %0b", want.last_pixel, got.last_pixel);
      end
    end
  endtask

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      // Sample the pre-edge handshake and result
      if (pop && !empty) check_pixel();
      if (allow_idle && stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Before any restart the reset fit of 1 by 1 applies: each pixel is last
  task automatic test_reset_state();
    send_pixel_request(1'b0);
    send_pixel_request(1'b0);
    send_pixel_request(1'b1);
  endtask

  // Top-down 4x4 into a 2x2 box: scan past the end to see the wrap to the first pixel
  task automatic test_scan_wrap();
    apply_config(32'd54, 32'd4, -32'sd4, 32'd2, 32'd2, 32'd10, 32'd20);
    send_pixel_request(1'b1);
    repeat (4) send_pixel_request(1'b0);
  endtask

  // Width governs on a flipped source, then height governs; both centered
  task automatic test_flip_and_center();
    apply_config(32'd1000, 32'd6, 32'd3, 32'd10, 32'd10, 32'd100, 32'd200);
    send_pixel_request(1'b1);
    repeat (3) send_pixel_request(1'b0);
    apply_config(32'd7, 32'd2, 32'd8, 32'd6, 32'd4, 32'd3, 32'd5);
    send_pixel_request(1'b1);
    send_pixel_request(1'b0);
  endtask

  // Largest sizes clamp to the maximum fit, with the largest data offset and box position
  task automatic test_field_extremes();
    apply_config(32'hFF_FFFF, 32'd8191, -32'sd8192, 32'd8191, 32'd8191, 32'd4095, 32'd4095);
    send_pixel_request(1'b1);
    repeat (2) send_pixel_request(1'b0);
    apply_config(32'd0, 32'd1, 32'd1, 32'd8191, 32'd8191, 32'd0, 32'd0);
    send_pixel_request(1'b1);
  endtask

  // Zero source or box sizes: no division by zero, fit at least 1, box
  // narrower than the draw area gives no centering offset
  task automatic test_zero_sizes();
    apply_config(32'd54, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
    send_pixel_request(1'b1);
    send_pixel_request(1'b0);
    apply_config(32'd54, 32'd5, 32'd0, 32'd0, 32'd3, 32'd2, 32'd2);
    send_pixel_request(1'b1);
    apply_config(32'd54, 32'd0, 32'd7, 32'd4, 32'd4, 32'd0, 32'd0);
    send_pixel_request(1'b1);
    send_pixel_request(1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Random scans
  // ---------------------------------------------------------------------------

  // Mostly small sizes so scans wrap; extremes and zero now and then
  function automatic logic [DATA_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 8191;
      2:       return MAX_DIM;
      3:       return $urandom_range(1, 8191);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_pos();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic randomize_config();
    logic [DATA_W-1:0] poff, sh;
    case ($urandom_range(0, 3))
      0:       poff = 0;
      1:       poff = 32'hFF_FFFF;
      default: poff = $urandom;
    endcase
    sh = pick_size();
    if ($urandom_range(0, 1)) sh = -sh;
    if ($urandom_range(0, 15) == 0) sh = -32'sd8192;
    apply_config(dressed(poff, POFF_W), dressed(pick_size(), SRCW_W),
                 dressed(sh, SRCH_W), dressed(pick_size(), BOX_W),
                 dressed(pick_size(), BOX_W), dressed(pick_pos(), POS_W),
                 dressed(pick_pos(), POS_W));
  endtask

  task automatic test_random_scans();
    longint unsigned scan_len;
    int unsigned     n;
    while (items_sent < ITEM_TARGET) begin
      allow_idle = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      randomize_config();
      if ($urandom_range(0, 9) < 7) begin
        // Restart, then scan; small draw areas go once or twice around
        send_pixel_request(1'b1);
        scan_len = longint'(draw_w) * draw_h;
        if (scan_len <= 20)
          n = 32'(scan_len * $urandom_range(1, 2) + $urandom_range(0, 2));
        else
          n = $urandom_range(1, 40);
        repeat (n) send_pixel_request(1'b0);
      end else begin
        // Noise: carry on the old scan under new registers, stray restarts
        repeat ($urandom_range(5, 30)) send_pixel_request($urandom_range(0, 3) == 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rst_ni    <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    push      <= 1'b0;
    restart_i <= 1'b0;
    allow_idle = 1'b1;
    shadow_cfg.data_offset = RST_DATA_OFFSET;
    shadow_cfg.src_width   = RST_SRC_WIDTH;
    shadow_cfg.src_height  = RST_SRC_HEIGHT;
    shadow_cfg.box_width   = RST_BOX_SIZE;
    shadow_cfg.box_height  = RST_BOX_SIZE;
    shadow_cfg.box_left    = RST_BOX_POS;
    shadow_cfg.box_top     = RST_BOX_POS;
    draw_w  = FIT_W'(1);
    draw_h  = FIT_W'(1);
    col_pos = '0;
    row_pos = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_scan_wrap();
    test_flip_and_center();
    test_field_extremes();
    test_zero_sizes();
    test_random_scans();

    // Drain, then give the block time to show any stray result
    allow_idle = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixel requests (%0d restarts) over %0d register setups;",
             items_sent, restarts_sent, config_phases);
    $display("checked %0d pixels, %0d of them last pixels; %0d mismatches.",
             pixels_checked, last_pixels_seen, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIME_LIMIT);
    $display("ERROR: timeout with %0d pixels still expected", pending_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
